// ===== hdl/kdh_pkg.sv =====
// Shared types, constants and plane normal tables for the k-DOP hull block.
package kdh_pkg;

    localparam int PLANE_CNT  = 8;
    localparam int PLANE_W    = $clog2(PLANE_CNT);
    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 10;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Unit normals, Q1.15, at 2*pi*i/PLANE_CNT
    localparam logic signed [15:0] NRM_X [PLANE_CNT] = '{
        16'sd32767, 16'sd23170, 16'sd0, -16'sd23170,
        -16'sd32767, -16'sd23170, 16'sd0, 16'sd23170};
    localparam logic signed [15:0] NRM_Y [PLANE_CNT] = '{
        16'sd0, 16'sd23170, 16'sd32767, 16'sd23170,
        16'sd0, -16'sd23170, -16'sd32767, -16'sd23170};

    // Cross product of adjacent normals; identical and positive for every pair
    localparam logic [29:0] DET = 30'd759211390;

    localparam int DIVD_W    = 63;   // dividend bits
    localparam int DIVS_W    = 41;   // divisor bits
    localparam int DIV_STEPS = DIVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic               accept;
        logic               proj;
        logic               seen_set;
        logic               clear;
        logic               mul1;
        logic               mul2;
        logic               dset;
        logic               dadd;
        logic               dstep;
        logic               fin;
        logic               axis;
        logic               rot;
        logic               out_load;
        logic               out_empty;
        logic               out_last;
        logic [PLANE_W-1:0] plane;
    } t_cmd;

    typedef struct packed {
        logic pix;
        logic last;
        logic seen;
        logic out_free;
    } t_sts;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ===== hdl/kdop_hull_from_mask_top.sv =====
// A set pixel goes through accept, 8 plane projections and a check; a clear one skips to the check.
// No new mask beat is taken until the last one is done; the shared
//   projection unit visits each of the 8 planes in turn, and the input is stalled meanwhile.
// Last pixel: 8 vertices, each as two axes of multiply, multiply, divider set-up, rounding
//   add, 63-step bit-serial divider and finish, plus an output beat; an empty mask gives one beat flagged empty.
// Reset (synchronous, active low) clears counters, seen flag and output valid.
module kdop_hull_from_mask_top
    import kdh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // mask input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_pixel_set,
    input  logic               i_last_pixel,
    // configuration: index 0 image_width, index 1 image_height
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_wdata,
    // vertex output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_vertex_x,
    output logic signed [15:0] o_vertex_y,
    output logic               o_hull_empty,
    output logic               o_last_vertex
);

    t_cmd cmd;
    t_sts sts;
    logic idle;

    // one mask beat at a time; the output register lets a vertex wait
    // while the next beat is taken
    assign o_stall = !idle;

    kdh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    kdh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel_set   (i_pixel_set),
        .i_last_pixel  (i_last_pixel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_hull_empty  (o_hull_empty),
        .o_last_vertex (o_last_vertex)
    );

endmodule

// ===== hdl/kdh_ctrl.sv =====
// Sequencer: steps projection, vertex arithmetic, divider and output beats.
module kdh_ctrl
    import kdh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROJ, S_CHK, S_EMPTY, S_MUL1, S_MUL2,
        S_DSET, S_DADD, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state             r_state;
    logic [PLANE_W-1:0] r_plane;
    logic               r_axis;
    logic [STEP_W-1:0]  r_cnt;

    always_comb begin
        o_cmd           = '0;
        o_cmd.plane     = r_plane;
        o_cmd.axis      = r_axis;
        o_cmd.accept    = (r_state == S_IDLE) && i_valid;
        o_cmd.proj      = (r_state == S_PROJ) && i_sts.pix;
        o_cmd.seen_set  = (r_state == S_PROJ) && i_sts.pix
                          && (r_plane == PLANE_W'(PLANE_CNT - 1));
        o_cmd.mul1      = (r_state == S_MUL1);
        o_cmd.mul2      = (r_state == S_MUL2);
        o_cmd.dset      = (r_state == S_DSET);
        o_cmd.dadd      = (r_state == S_DADD);
        o_cmd.dstep     = (r_state == S_DIV);
        o_cmd.fin       = (r_state == S_FIN);
        if (r_state == S_EMPTY && i_sts.out_free) begin
            o_cmd.out_load  = 1'b1;
            o_cmd.out_empty = 1'b1;
            o_cmd.out_last  = 1'b1;
            o_cmd.clear     = 1'b1;
        end
        if (r_state == S_OUT && i_sts.out_free) begin
            o_cmd.out_load = 1'b1;
            o_cmd.rot      = 1'b1;
            o_cmd.out_last = (r_plane == '0);
            o_cmd.clear    = (r_plane == '0);
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plane <= '0;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_PROJ;
                        r_plane <= '0;
                    end
                end
                S_PROJ: begin
                    if (!i_sts.pix || r_plane == PLANE_W'(PLANE_CNT - 1)) begin
                        r_state <= S_CHK;
                        r_plane <= '0;
                    end else begin
                        r_plane <= r_plane + 1'b1;
                    end
                end
                S_CHK: begin
                    if (!i_sts.last) begin
                        r_state <= S_IDLE;
                    end else if (!i_sts.seen) begin
                        r_state <= S_EMPTY;
                    end else begin
                        r_state <= S_MUL1;
                        r_plane <= PLANE_W'(PLANE_CNT - 1);
                        r_axis  <= 1'b0;
                    end
                end
                S_EMPTY: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_DSET;
                S_DSET: r_state <= S_DADD;
                S_DADD: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_MUL1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_axis <= 1'b0;
                        if (r_plane == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_plane <= r_plane - 1'b1;
                            r_state <= S_MUL1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/kdh_dp.sv =====
// Datapath: counters, plane maxima ring, shared multiplier, divider, output register.
module kdh_dp
    import kdh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_pixel_set,
    input  logic                   i_last_pixel,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_wdata,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic signed [15:0]     o_vertex_x,
    output logic signed [15:0]     o_vertex_y,
    output logic                   o_hull_empty,
    output logic                   o_last_vertex
);

    logic [DIM_W-1:0]        r_width, r_height;
    logic [CNT_W-1:0]        r_col, r_row;
    logic                    r_seen, r_pix, r_last;
    logic signed [11:0]      r_cx, r_cy;
    logic signed [31:0]      r_max [PLANE_CNT];
    logic signed [47:0]      r_p1;
    logic signed [48:0]      r_num;
    logic                    r_neg;
    logic [DIVD_W-2:0]       r_mn;
    logic [DIVS_W-1:0]       r_md;
    logic [DIVD_W-1:0]       r_quo;
    logic [DIVS_W-1:0]       r_rem;
    logic signed [15:0]      r_vx, r_vy;
    logic                    r_o_valid;

    logic [DIM_W-1:0]        w, h;
    logic [CNT_W-1:0]        col_eff, row_eff;
    logic [DIM_W-1:0]        col_nxt, row_nxt;

    assign w = clamp_dim(r_width);
    assign h = clamp_dim(r_height);
    assign col_eff = ({1'b0, r_col} >= w) ? '0 : r_col;
    assign row_eff = ({1'b0, r_row} >= h) ? '0 : r_row;
    assign col_nxt = {1'b0, col_eff} + 1'b1;
    assign row_nxt = {1'b0, row_eff} + 1'b1;

    // Projection: best corner of the texel is the low corner plus 2*n where n > 0
    logic signed [15:0] pnx, pny;
    logic signed [31:0] best;
    assign pnx  = NRM_X[i_cmd.plane];
    assign pny  = NRM_Y[i_cmd.plane];
    assign best = 32'(pnx) * 32'(r_cx) + 32'(pny) * 32'(r_cy)
                + ((pnx > 0) ? 32'(pnx) * 2 : 32'sd0)
                + ((pny > 0) ? 32'(pny) * 2 : 32'sd0);

    // Vertex: plane i sits at the top tap, plane i+1 at the bottom tap
    logic [PLANE_W-1:0]  pj;
    logic signed [31:0]  di, dj, ma;
    logic signed [15:0]  mb;
    logic signed [47:0]  mprod;
    assign pj = i_cmd.plane + 1'b1;
    assign di = r_max[PLANE_CNT-1];
    assign dj = r_max[0];
    always_comb begin
        if (i_cmd.mul1) begin
            ma = i_cmd.axis ? dj : di;
            mb = i_cmd.axis ? NRM_X[i_cmd.plane] : NRM_Y[pj];
        end else begin
            ma = i_cmd.axis ? di : dj;
            mb = i_cmd.axis ? NRM_X[pj] : NRM_Y[i_cmd.plane];
        end
    end
    assign mprod = ma * mb;

    logic [48:0]        num_abs;
    assign num_abs = r_num[48] ? 49'(-r_num) : 49'(r_num);

    logic [DIVS_W:0]    rem_sh;
    logic               qbit;
    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_md});

    // Rounding finish: snap just past +/-0.5, then saturate
    logic               big;
    logic signed [16:0] v17, vs;
    logic signed [15:0] vfin;
    assign big = |r_quo[DIVD_W-1:15];
    assign v17 = r_neg ? -$signed({2'b00, r_quo[14:0]}) : $signed({2'b00, r_quo[14:0]});
    always_comb begin
        vs = v17;
        if (v17 >= 17'sd8193 && v17 <= 17'sd8208) vs = 17'sd8192;
        if (v17 <= -17'sd8193 && v17 >= -17'sd8208) vs = -17'sd8192;
        if (big) vfin = r_neg ? -16'sd32768 : 16'sd32767;
        else     vfin = vs[15:0];
    end

    assign o_sts.pix      = r_pix;
    assign o_sts.last     = r_last;
    assign o_sts.seen     = r_seen;
    assign o_sts.out_free = !r_o_valid || !i_stall;
    assign o_valid        = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= DIM_W'(64);
            r_height  <= DIM_W'(64);
            r_col     <= '0;
            r_row     <= '0;
            r_seen    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_wdata;
                    REG_HEIGHT: r_height <= i_cfg_wdata;
                    default:    r_width  <= r_width;
                endcase
            end
            if (i_cmd.accept) begin
                if (col_nxt >= w) begin
                    r_col <= '0;
                    r_row <= (row_nxt >= h) ? '0 : row_nxt[CNT_W-1:0];
                end else begin
                    r_col <= col_nxt[CNT_W-1:0];
                    r_row <= row_eff;
                end
            end
            if (i_cmd.seen_set) r_seen <= 1'b1;
            if (i_cmd.clear) begin
                r_seen <= 1'b0;
                r_col  <= '0;
                r_row  <= '0;
            end
            if (i_cmd.out_load)  r_o_valid <= 1'b1;
            else if (!i_stall)   r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix  <= i_pixel_set;
            r_last <= i_last_pixel;
            r_cx   <= $signed({1'b0, col_eff, 1'b0}) - $signed({1'b0, w});
            r_cy   <= $signed({1'b0, row_eff, 1'b0}) - $signed({1'b0, h});
        end
        if (i_cmd.proj) begin
            for (int k = 0; k < PLANE_CNT - 1; k++) r_max[k] <= r_max[k+1];
            r_max[PLANE_CNT-1] <= (!r_seen || best > r_max[0]) ? best : r_max[0];
        end
        if (i_cmd.rot) begin
            for (int k = 1; k < PLANE_CNT; k++) r_max[k] <= r_max[k-1];
            r_max[0] <= r_max[PLANE_CNT-1];
        end
        if (i_cmd.mul1) r_p1 <= mprod;
        if (i_cmd.mul2) r_num <= 49'(r_p1) - 49'(mprod);
        if (i_cmd.dset) begin
            r_neg <= r_num[48];
            r_mn  <= {num_abs, 13'b0};
            r_md  <= DIVS_W'(DET) * DIVS_W'(i_cmd.axis ? h : w);
        end
        if (i_cmd.dadd) begin
            r_quo <= {1'b0, r_mn} + DIVD_W'(r_md[DIVS_W-1:1]);
            r_rem <= '0;
        end
        if (i_cmd.dstep) begin
            r_rem <= qbit ? DIVS_W'(rem_sh - {1'b0, r_md}) : rem_sh[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], qbit};
        end
        if (i_cmd.fin) begin
            if (i_cmd.axis) r_vy <= vfin;
            else            r_vx <= vfin;
        end
        if (i_cmd.out_load) begin
            o_vertex_x    <= i_cmd.out_empty ? 16'sd0 : r_vx;
            o_vertex_y    <= i_cmd.out_empty ? 16'sd0 : r_vy;
            o_hull_empty  <= i_cmd.out_empty;
            o_last_vertex <= i_cmd.out_last;
        end
    end

endmodule
